/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define UCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define UCD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ucd_pkg.sv */
// Shared types, constants and helper functions of the percent decoder.
`timescale 1ns / 1ps
package ucd_pkg;

  localparam int unsigned WORK_DEPTH = 6;
  localparam int unsigned CNT_W      = 3;
  localparam logic [CNT_W-1:0] N_WORK = 3'd6;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [15:0] UTF_LIM1      = 16'h0080;
  localparam logic [15:0] UTF_LIM2      = 16'h0800;
  localparam logic [15:0] SURR_LO       = 16'hD800;
  localparam logic [15:0] SURR_HI       = 16'hE000;
  localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF_CONT      = 8'h80;
  localparam logic [7:0]  UTF_CONT_MASK = 8'h3F;

  typedef enum logic [2:0] {
    ACT_LIT,
    ACT_PCT,
    ACT_STOP,
    ACT_BYTE,
    ACT_UTF
  } ucd_act_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       emit_utf;
    logic [1:0] utf_idx;
    logic       flush;
  } ucd_cmd_t;

  typedef struct packed {
    logic       n_zero;
    ucd_act_t   act;
    logic [1:0] step_ulen;
    logic [1:0] code_ulen;
    logic       emit_ok;
    logic       pend_valid;
  } ucd_status_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  // Number of UTF-8 bytes for a 16-bit code; surrogates give none.
  function automatic logic [1:0] utf_len(input logic [15:0] code);
    logic [1:0] len;
    if (code < UTF_LIM1) begin
      len = 2'd1;
    end else if (code < UTF_LIM2) begin
      len = 2'd2;
    end else if ((code >= SURR_LO) && (code < SURR_HI)) begin
      len = 2'd0;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf_byte(input logic [15:0] code, input logic [1:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    case (len)
      2'd1: b = {1'b0, code[6:0]};
      2'd2: b = (idx == 2'd0) ? (UTF_LEAD2 | {3'b000, code[10:6]})
                              : (UTF_CONT | (UTF_CONT_MASK & {2'b00, code[5:0]}));
      2'd3: begin
        case (idx)
          2'd0:    b = UTF_LEAD3 | {4'h0, code[15:12]};
          2'd1:    b = UTF_CONT | (UTF_CONT_MASK & {2'b00, code[11:6]});
          default: b = UTF_CONT | (UTF_CONT_MASK & {2'b00, code[5:0]});
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/ucd_datapath.sv */
// Datapath: work buffer, escape decode, pending byte and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ucd_datapath
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        plus_to_space_wr,
  input  logic        plus_to_space,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  ucd_cmd_t    cmd,
  output ucd_status_t st
);

  logic [7:0]       work [WORK_DEPTH];
  logic [CNT_W-1:0] n;
  logic             last_flag;
  logic             pts;
  logic [15:0]      code;
  logic [7:0]       pend_byte;
  logic             pend_valid;

  logic [7:0]       c0;
  logic             uform;
  logic [CNT_W-1:0] n_rest;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] avail;
  logic [7:0]       d [4];
  logic             bad;
  logic             short_esc;
  logic [15:0]      val;
  ucd_act_t         act;
  logic [CNT_W-1:0] shift;
  logic [7:0]       emit_byte;
  logic             emit_now;
  logic             out_free;
  logic [1:0]       step_ulen;
  logic [1:0]       code_ulen;

  always_comb begin
    c0     = work[0];
    uform  = (work[1] == CHAR_U);
    n_rest = uform ? (n - 3'd2) : (n - 3'd1);
    need   = uform ? 3'd4 : 3'd2;
    avail  = (n_rest > need) ? need : n_rest;
    for (int k = 0; k < 4; k++) begin
      d[k] = uform ? work[k + 2] : work[k + 1];
    end
    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < avail) && !hex_ok(d[k])) begin
        bad = 1'b1;
      end
    end
    short_esc = (avail < need);
    val = uform ? {hex_val(d[0]), hex_val(d[1]), hex_val(d[2]), hex_val(d[3])}
                : {8'h00, hex_val(d[0]), hex_val(d[1])};

    if (c0 != CHAR_PCT) begin
      act = ACT_LIT;
    end else if (n < 3'd2) begin
      act = last_flag ? ACT_PCT : ACT_STOP;
    end else if (bad || (short_esc && last_flag)) begin
      act = ACT_PCT;
    end else if (short_esc) begin
      act = ACT_STOP;
    end else begin
      act = uform ? ACT_UTF : ACT_BYTE;
    end

    step_ulen = utf_len(val);
    code_ulen = utf_len(code);

    case (act)
      ACT_BYTE: shift = 3'd3;
      ACT_UTF:  shift = 3'd6;
      default:  shift = 3'd1;
    endcase

    if (cmd.emit_utf) begin
      emit_byte = utf_byte(code, code_ulen, cmd.utf_idx);
    end else begin
      case (act)
        ACT_LIT:  emit_byte = (pts && (c0 == CHAR_PLUS)) ? CHAR_SPACE : c0;
        ACT_PCT:  emit_byte = CHAR_PCT;
        ACT_BYTE: emit_byte = val[7:0];
        ACT_UTF:  emit_byte = utf_byte(val, step_ulen, 2'd0);
        default:  emit_byte = c0;
      endcase
    end

    emit_now = cmd.emit_utf ||
               (cmd.step && !((act == ACT_UTF) && (step_ulen == 2'd0)));
    out_free = !out_valid || out_ready;

    st.n_zero     = (n == '0);
    st.act        = act;
    st.step_ulen  = step_ulen;
    st.code_ulen  = code_ulen;
    st.emit_ok    = !pend_valid || out_free;
    st.pend_valid = pend_valid;
  end

  // Payload storage: work buffer, latched code, pending byte, output byte.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work[n] <= in_byte;
    end else if (cmd.step) begin
      for (int i = 0; i < WORK_DEPTH; i++) begin
        if (i + int'(shift) < WORK_DEPTH) begin
          work[i] <= work[i + int'(shift)];
        end
      end
      if (act == ACT_UTF) begin
        code <= val;
      end
    end
    if (emit_now) begin
      pend_byte <= emit_byte;
    end
    if (emit_now && pend_valid) begin
      out_byte <= pend_byte;
      out_last <= 1'b0;
    end else if (cmd.flush) begin
      out_byte <= pend_byte;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= '0;
      last_flag  <= 1'b0;
      pts        <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (plus_to_space_wr) begin
        pts <= plus_to_space;
      end
      if (cmd.load) begin
        n         <= n + 3'd1;
        last_flag <= in_last;
      end else if (cmd.step) begin
        n <= n - shift;
      end
      if (emit_now) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((emit_now && pend_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `UCD_ASSERT(a_load_room, cmd.load |-> (n < N_WORK), "load with a full work buffer")
  `UCD_ASSERT(a_no_overwrite, (emit_now && pend_valid) |-> out_free, "output beat overwritten")
  `UCD_ASSERT_RST(a_reset_clear, rst |=> (!out_valid && !pend_valid), "not cleared by reset")

endmodule

/* rtl/core/ucd_ctrl.sv */
// Controller: sequences load, scan steps, UTF-8 byte emission and end-of-item flush.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ucd_ctrl
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ucd_status_t st,
  output ucd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UTF,
    ST_FLUSH
  } state_t;

  state_t     state;
  logic [1:0] utf_idx;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.utf_idx = utf_idx;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_SCAN: begin
        if (!st.n_zero) begin
          case (st.act)
            ACT_STOP: cmd.step = 1'b0;
            ACT_UTF:  cmd.step = (st.step_ulen == 2'd0) || st.emit_ok;
            default:  cmd.step = st.emit_ok;
          endcase
        end
      end
      ST_UTF:   cmd.emit_utf = st.emit_ok;
      ST_FLUSH: cmd.flush = st.pend_valid && st.emit_ok;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      utf_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (st.n_zero || (st.act == ACT_STOP)) begin
            state <= ST_FLUSH;
          end else if (cmd.step && (st.act == ACT_UTF) && (st.step_ulen >= 2'd2)) begin
            state   <= ST_UTF;
            utf_idx <= 2'd1;
          end
        end
        ST_UTF: begin
          if (st.emit_ok) begin
            if (utf_idx == (st.code_ulen - 2'd1)) begin
              state <= ST_SCAN;
            end else begin
              utf_idx <= utf_idx + 2'd1;
            end
          end
        end
        ST_FLUSH: begin
          if (!st.pend_valid || st.emit_ok) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `UCD_ASSERT(a_utf_idx_range, (state == ST_UTF) |-> (utf_idx < st.code_ulen), "UTF-8 index out of range")
  `UCD_ASSERT(a_idle_clean, (state == ST_IDLE) |-> !st.pend_valid, "pending beat left at idle")

endmodule

/* rtl/core/url_percent_decoder_core.sv */
// Top level of the URI percent decoder with %u escapes.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready, in_byte, in_last) carries one raw byte of an
//   encoded URI per beat; in_last marks the final byte of the string and flushes
//   any escape prefix still held. Output channel (out_valid/out_ready, out_byte,
//   out_last) gives the decoded bytes; out_last is set on the final output beat
//   caused by an input beat. An input beat that settles nothing gives no output.
//   %XX becomes one byte, %uXXXX its UTF-8 form (one to three bytes, none for a
//   surrogate), '+' becomes a space while plus_to_space is set. A malformed or
//   cut-off escape gives a literal '%' and the bytes after it are scanned again.
//   The user must write plus_to_space via plus_to_space_wr while idle; not enforced.
// Timing
//   in_ready is high only between items, so a byte is accepted only once the previous
//   one has been scanned and flushed. The scan loop settles one escape or literal per
//   cycle while the output can take a byte, and pauses while the extra bytes of a
//   UTF-8 form are sent. A one-byte holding stage lets out_last mark the final beat;
//   a held byte goes out when the next byte is emitted or at the flush.
// Reset and stalls
//   rst (synchronous) empties the held escape prefix, the output register and
//   clears plus_to_space. When out_ready is low the scan holds at the next
//   output byte; the output register keeps its beat until it is taken.
module url_percent_decoder_core
  import ucd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       plus_to_space_wr,
  input  logic       plus_to_space,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  ucd_cmd_t    cmd;
  ucd_status_t st;

  // Sequencer: decides when to load, step, emit and flush.
  ucd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage and decode of the held prefix plus the new byte.
  ucd_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .plus_to_space_wr (plus_to_space_wr),
    .plus_to_space    (plus_to_space),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .cmd              (cmd),
    .st               (st)
  );

endmodule
